// ===== hw/rtl/cbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbcd_pkg
// Shared types and constants of the cluster block coordinate decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbcd_pkg;

    // one stream byte and its start marker
    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_req;
    } t_in_item;

    // one decoded cluster position
    typedef struct packed {
        logic [31:0] x_coord;
        logic [31:0] y_coord;
        logic [31:0] block_number;
    } t_out_item;

    // configuration register indexes
    localparam int unsigned CBCD_CFG_IDX_W        = 1;
    localparam int unsigned CBCD_CFG_DATA_W       = 16;
    localparam logic [CBCD_CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 1'd0;
    localparam logic [CBCD_CFG_IDX_W-1:0] CFG_BLOCKS_PER_LINE = 1'd1;

    // register reset values
    localparam logic [7:0]  CBCD_BLOCK_SIZE_RST      = 8'd25;
    localparam logic [15:0] CBCD_BLOCKS_PER_LINE_RST = 16'd82;

    // offset added to every coordinate
    localparam logic [31:0] CBCD_COORD_OFFSET = 32'd1000;

    // default depth of the result queue
    localparam int unsigned CBCD_OUT_DEPTH = 2;

endpackage

`default_nettype wire

// ===== hw/rtl/cbcd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cbcd_out_fifo
// Small result queue between the decoder state and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cbcd_out_fifo
    import cbcd_pkg::*;
#(
    parameter int unsigned DEPTH = CBCD_OUT_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_push_data,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_out_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cluster_block_coord_decoder_top.sv =====
// ----------------------------------------------------------------------------
// cluster_block_coord_decoder_top
// Parses a block-compressed cluster position byte stream into coordinates.
// ----------------------------------------------------------------------------
// The decoder takes one stream byte per clock cycle. Each accepted byte
// updates the parse state at the clock edge that accepts it, and a dy byte
// places its x, y and block number into the result queue (two entries by
// default) at that same edge.
// o_in_ready drops only while the result queue is full; with the output
// side always ready the block sustains one byte per cycle. A byte with
// start_req set restarts header parsing; configuration writes are taken
// at any time but belong between streams.
`default_nettype none

module cluster_block_coord_decoder_top
    import cbcd_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = CBCD_OUT_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [CBCD_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CBCD_CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire t_in_item                   i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output t_out_item                       o_out_data
);

    // parse phases
    localparam logic [2:0] PH_VERSION     = 3'd0;
    localparam logic [2:0] PH_TOTAL       = 3'd1;
    localparam logic [2:0] PH_FIRST_COUNT = 3'd2;
    localparam logic [2:0] PH_COUNT       = 3'd3;
    localparam logic [2:0] PH_DX          = 3'd4;
    localparam logic [2:0] PH_DY          = 3'd5;
    localparam logic [2:0] PH_DONE        = 3'd6;

    logic [7:0]  r_block_size;
    logic [15:0] r_blocks_per_line;

    logic [2:0]  r_phase,      n_phase;
    logic [1:0]  r_hdr_idx,    n_hdr_idx;
    logic [31:0] r_block_total, n_block_total;
    logic [31:0] r_block_cnt,  n_block_cnt;
    logic [7:0]  r_clusters,   n_clusters;
    logic [15:0] r_column,     n_column;
    logic [31:0] r_x_base,     n_x_base;
    logic [31:0] r_y_base,     n_y_base;
    logic [7:0]  r_dx,         n_dx;

    logic        in_fire;
    logic        fifo_full;
    logic        res_push;
    t_out_item   res_data;
    logic [11:0] base_step;
    logic        line_wrap;
    logic [31:0] shifted_byte;

    // phase after the block's count or a cluster is handled
    function automatic logic [2:0] next_phase(input logic [7:0]  clusters,
                                              input logic [31:0] count,
                                              input logic [31:0] total);
        logic [2:0] ph;
        if (clusters != 8'd0) begin
            ph = PH_DX;
        end else if (count < total) begin
            ph = PH_COUNT;
        end else begin
            ph = PH_DONE;
        end
        return ph;
    endfunction

    assign o_in_ready = !fifo_full;
    assign in_fire    = i_in_valid && o_in_ready;

    // base step is 10 * block_size
    assign base_step = 12'({r_block_size, 3'b000}) + 12'({r_block_size, 1'b0});
    assign line_wrap = (({1'b0, r_column} + 17'd1) >= {1'b0, r_blocks_per_line});
    assign shifted_byte = 32'(i_in_data.byte_in) << {r_hdr_idx, 3'b000};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size      <= CBCD_BLOCK_SIZE_RST;
            r_blocks_per_line <= CBCD_BLOCKS_PER_LINE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BLOCK_SIZE:      r_block_size      <= i_cfg_data[7:0];
                CFG_BLOCKS_PER_LINE: r_blocks_per_line <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state machine and result generation
    always_comb begin
        n_phase       = r_phase;
        n_hdr_idx     = r_hdr_idx;
        n_block_total = r_block_total;
        n_block_cnt   = r_block_cnt;
        n_clusters    = r_clusters;
        n_column      = r_column;
        n_x_base      = r_x_base;
        n_y_base      = r_y_base;
        n_dx          = r_dx;
        res_push      = 1'b0;
        res_data.x_coord      = r_x_base + 32'(r_dx) + CBCD_COORD_OFFSET;
        res_data.y_coord      = r_y_base + 32'(i_in_data.byte_in) + CBCD_COORD_OFFSET;
        res_data.block_number = r_block_cnt - 32'd1;
        if (in_fire) begin
            if (i_in_data.start_req) begin
                // restart: clear stream state, byte is the version byte
                n_phase       = PH_TOTAL;
                n_hdr_idx     = 2'd0;
                n_block_total = '0;
                n_block_cnt   = '0;
                n_clusters    = '0;
                n_column      = '0;
                n_x_base      = '0;
                n_y_base      = '0;
                n_dx          = '0;
            end else begin
                unique case (r_phase)
                    PH_VERSION: begin
                        n_phase   = PH_TOTAL;
                        n_hdr_idx = 2'd0;
                    end
                    PH_TOTAL: begin
                        n_block_total = r_block_total | shifted_byte;
                        n_hdr_idx     = r_hdr_idx + 2'd1;
                        if (r_hdr_idx == 2'd3) begin
                            n_phase = PH_FIRST_COUNT;
                        end
                    end
                    PH_FIRST_COUNT: begin
                        n_clusters  = i_in_data.byte_in;
                        n_block_cnt = 32'd1;
                        n_column    = '0;
                        n_x_base    = '0;
                        n_y_base    = '0;
                        n_phase     = next_phase(i_in_data.byte_in, 32'd1, r_block_total);
                    end
                    PH_COUNT: begin
                        n_clusters  = i_in_data.byte_in;
                        n_block_cnt = r_block_cnt + 32'd1;
                        if (line_wrap) begin
                            n_column = '0;
                            n_x_base = '0;
                            n_y_base = r_y_base + 32'(base_step);
                        end else begin
                            n_column = r_column + 16'd1;
                            n_x_base = r_x_base + 32'(base_step);
                        end
                        n_phase = next_phase(i_in_data.byte_in, n_block_cnt,
                                             r_block_total);
                    end
                    PH_DX: begin
                        n_dx    = i_in_data.byte_in;
                        n_phase = PH_DY;
                    end
                    PH_DY: begin
                        res_push   = 1'b1;
                        n_clusters = r_clusters - 8'd1;
                        n_phase    = next_phase(n_clusters, r_block_cnt, r_block_total);
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_VERSION;
            r_hdr_idx     <= '0;
            r_block_total <= '0;
            r_block_cnt   <= '0;
            r_clusters    <= '0;
            r_column      <= '0;
            r_x_base      <= '0;
            r_y_base      <= '0;
            r_dx          <= '0;
        end else begin
            r_phase       <= n_phase;
            r_hdr_idx     <= n_hdr_idx;
            r_block_total <= n_block_total;
            r_block_cnt   <= n_block_cnt;
            r_clusters    <= n_clusters;
            r_column      <= n_column;
            r_x_base      <= n_x_base;
            r_y_base      <= n_y_base;
            r_dx          <= n_dx;
        end
    end

    // result queue
    cbcd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_push),
        .i_push_data (res_data),
        .o_full      (fifo_full),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cbcd_checker.sv =====
// ----------------------------------------------------------------------------
// cbcd_checker
// Port-level assertions for the cluster block coordinate decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module cbcd_checker
    import cbcd_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire t_in_item                   i_in_data,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire t_out_item                  o_out_data
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or vanished");

    // input backpressure only while results are pending
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // a start byte never yields a result
    a_start_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && i_in_valid && o_in_ready && i_in_data.start_req)
        |=> !o_out_valid)
        else $error("start byte produced a result");

endmodule

bind cluster_block_coord_decoder_top cbcd_checker u_cbcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/sv/tb_cluster_block_coord_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_cluster_block_coord_decoder_top
// Self-checking bench for the cluster block coordinate decoder.
// ----------------------------------------------------------------------------
// Drives position streams byte by byte and tracks the parse state in a
// scoreboard. The scoreboard predicts every cluster coordinate and compares
// it with what the decoder returns. Streams cover headers, empty blocks,
// restarts, trailing bytes and open streams that continue after a register
// change, under several register settings and handshake idling modes.
`default_nettype none

module tb_cluster_block_coord_decoder_top
    import cbcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // parse state of the stream tracker
    typedef enum logic [2:0] {
        ST_VERSION,
        ST_TOTAL,
        ST_FIRST_COUNT,
        ST_COUNT,
        ST_DX,
        ST_DY,
        ST_DONE
    } t_parse_state;

    // scoreboard: tracks the stream and holds the coordinates still owed
    class t_coord_scoreboard;
        logic [7:0]   bsize;
        logic [15:0]  bpl;
        t_parse_state state;
        logic [1:0]   hdr_idx;
        logic [31:0]  blk_total;
        logic [31:0]  blk_count;
        logic [7:0]   clusters_left;
        logic [15:0]  column;
        logic [31:0]  x_base;
        logic [31:0]  y_base;
        logic [7:0]   dx_held;
        t_out_item    expected_coords[$];
        int           errors;
        int           coords_checked;
        int           bytes_seen;
        int           restarts;

        function new();
            bsize = CBCD_BLOCK_SIZE_RST;
            bpl = CBCD_BLOCKS_PER_LINE_RST;
            errors = 0;
            coords_checked = 0;
            bytes_seen = 0;
            restarts = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            state = ST_VERSION;
            hdr_idx = 2'd0;
            blk_total = 32'd0;
            blk_count = 32'd0;
            clusters_left = 8'd0;
            column = 16'd0;
            x_base = 32'd0;
            y_base = 32'd0;
            dx_held = 8'd0;
        endfunction

        function void set_register(logic [CBCD_CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_BLOCK_SIZE:      bsize = data[7:0];
                CFG_BLOCKS_PER_LINE: bpl = data;
                default: ;
            endcase
        endfunction

        // next phase once the current block's clusters are handled
        function void pick_next();
            if (clusters_left != 8'd0) state = ST_DX;
            else if (blk_count < blk_total) state = ST_COUNT;
            else state = ST_DONE;
        endfunction

        // move to the next block position, wrapping at the end of a row
        function void advance_block();
            logic [31:0] stride;
            stride = 32'd10 * {24'd0, bsize};
            if ({16'd0, column} + 32'd1 >= {16'd0, bpl}) begin
                column = 16'd0;
                x_base = 32'd0;
                y_base = y_base + stride;
            end else begin
                column = column + 16'd1;
                x_base = x_base + stride;
            end
        endfunction

        // note one accepted stream byte
        function void note_byte(t_in_item it);
            t_out_item coord;
            bytes_seen++;
            if (it.start_req) begin
                clear_stream();
                restarts++;
            end
            case (state)
                ST_VERSION: begin
                    state = ST_TOTAL;
                    hdr_idx = 2'd0;
                end
                ST_TOTAL: begin
                    blk_total = blk_total | ({24'd0, it.byte_in} << (8 * hdr_idx));
                    if (hdr_idx == 2'd3) begin
                        hdr_idx = 2'd0;
                        state = ST_FIRST_COUNT;
                    end else begin
                        hdr_idx = hdr_idx + 2'd1;
                    end
                end
                ST_FIRST_COUNT: begin
                    clusters_left = it.byte_in;
                    blk_count = 32'd1;
                    column = 16'd0;
                    x_base = 32'd0;
                    y_base = 32'd0;
                    pick_next();
                end
                ST_COUNT: begin
                    clusters_left = it.byte_in;
                    blk_count = blk_count + 32'd1;
                    advance_block();
                    pick_next();
                end
                ST_DX: begin
                    dx_held = it.byte_in;
                    state = ST_DY;
                end
                ST_DY: begin
                    coord.x_coord = x_base + {24'd0, dx_held} + CBCD_COORD_OFFSET;
                    coord.y_coord = y_base + {24'd0, it.byte_in} + CBCD_COORD_OFFSET;
                    coord.block_number = blk_count - 32'd1;
                    expected_coords.push_back(coord);
                    clusters_left = clusters_left - 8'd1;
                    pick_next();
                end
                default: state = ST_DONE;
            endcase
        endfunction

        // compare one returned coordinate with the oldest one owed
        function void check_coord(t_out_item got);
            t_out_item want;
            if (expected_coords.size() == 0) begin
                $error("unexpected coordinate x=%0d y=%0d block=%0d",
                       got.x_coord, got.y_coord, got.block_number);
                errors++;
                return;
            end
            want = expected_coords.pop_front();
            coords_checked++;
            if (got.x_coord !== want.x_coord) begin
                $error("x_coord mismatch: expected %0d, actual %0d",
                       want.x_coord, got.x_coord);
                errors++;
            end
            if (got.y_coord !== want.y_coord) begin
                $error("y_coord mismatch: expected %0d, actual %0d",
                       want.y_coord, got.y_coord);
                errors++;
            end
            if (got.block_number !== want.block_number) begin
                $error("block_number mismatch: expected %0d, actual %0d",
                       want.block_number, got.block_number);
                errors++;
            end
        endfunction

        function int pending();
            return expected_coords.size();
        endfunction
    endclass

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BYTES  = 12;
    localparam int SETTLE_CYCLES = 4;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CBCD_CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_SIZE;
    logic [CBCD_CFG_DATA_W-1:0] cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    t_in_item                  in_data = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    t_out_item                 out_data;

    t_coord_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int settings_applied = 0;

    cluster_block_coord_decoder_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock
    always #5 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor both channels at each edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_coord(out_data);
            if (in_valid && in_ready) sb.note_byte(in_data);
        end
    end

    // send one stream byte as one input transaction
    task automatic send_byte(input logic [7:0] b, input logic s);
        t_in_item it;
        it.byte_in = b;
        it.start_req = s;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // one block: count byte then that many dx, dy pairs
    task automatic send_block(input int n);
        send_byte(8'(n), 1'b0);
        repeat (n) begin
            send_byte(8'($urandom_range(255)), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // header with the given block total, then a number of random blocks
    task automatic send_stream(input logic [31:0] total, input int n_blocks,
                               input int max_clusters);
        send_byte(8'($urandom_range(255)), 1'b1);
        for (int i = 0; i < 4; i++) send_byte(total[8*i +: 8], 1'b0);
        for (int b = 0; b < n_blocks; b++) begin
            if ($urandom_range(99) < 15) send_block(0);
            else send_block($urandom_range(max_clusters, 1));
        end
    endtask

    // well-formed, truncated, or overlong stream with random content
    task automatic send_random_stream(input bit leave_open);
        int n_blocks;
        int sel;
        logic [31:0] total;
        n_blocks = $urandom_range(8, 1);
        sel = $urandom_range(99);
        if (leave_open) total = n_blocks + 4;
        else if (sel < 65) total = n_blocks;
        else if (sel < 80) total = $urandom;
        else total = $urandom_range(n_blocks - 1, 0);
        send_stream(total, n_blocks, 6);
    endtask

    // both registers, written back to back while the decoder is idle
    task automatic apply_settings(input logic [15:0] bs_word, input logic [15:0] bpl_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data <= bs_word;
        @(posedge clk);
        sb.set_register(CFG_BLOCK_SIZE, bs_word);
        cfg_index <= CFG_BLOCKS_PER_LINE;
        cfg_data <= bpl_word;
        @(posedge clk);
        sb.set_register(CFG_BLOCKS_PER_LINE, bpl_word);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // stop sending and wait until every owed coordinate has arrived
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // main sequence
    initial begin
        int phase_start;
        logic [15:0] bs_word;
        logic [15:0] bpl_word;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first stream right after reset, no start marker, extreme pair bytes
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // zero block total: first block still decoded, then trailing bytes ignored
        send_byte(8'hA5, 1'b1);
        repeat (4) send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        // restart in the middle of a header
        send_byte(8'h00, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            bs_word = {8'($urandom_range(255)), 8'd0};
            case (p)
                0: begin bs_word[7:0] = 8'd1;   bpl_word = 16'd1;     end
                1: begin bs_word[7:0] = 8'd255; bpl_word = 16'd65535; end
                2: begin bs_word[7:0] = 8'd0;   bpl_word = 16'd0;     end
                3: begin
                    bs_word[7:0] = 8'($urandom_range(255, 1));
                    bpl_word = 16'($urandom_range(5, 2));
                end
                4: begin bs_word[7:0] = CBCD_BLOCK_SIZE_RST; bpl_word = 16'd2; end
                default: begin
                    bs_word[7:0] = 8'($urandom_range(255, 1));
                    bpl_word = 16'($urandom_range(65535, 1));
                end
            endcase
            apply_settings(bs_word, bpl_word);
            phase_start = bytes_sent;

            // continue the stream left open before the register change
            if (p > 0) repeat (3) send_block($urandom_range(3));

            // one block with the largest cluster count
            if (p == 1) send_stream(32'd3, 2, 1);
            if (p == 1) send_block(255);

            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(99) < 80) begin
                    send_random_stream(1'b0);
                end else begin
                    repeat ($urandom_range(8, 1))
                        send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
                end
            end
            send_random_stream(1'b1);
            drain();
        end

        if (sb.pending() != 0) begin
            $error("%0d coordinates never returned", sb.pending());
            sb.errors++;
        end
        $display("Run covered %0d stream bytes with %0d restarts and %0d coordinates checked",
                 sb.bytes_seen, sb.restarts, sb.coords_checked);
        $display("under %0d register settings and four idling modes on both channels",
                 settings_applied);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/cbcd_pkg.sv
hw/rtl/cbcd_out_fifo.sv
hw/rtl/cluster_block_coord_decoder_top.sv
hw/rtl/cbcd_checker.sv
tb/sv/tb_cluster_block_coord_decoder_top.sv
